// File: rtl/core/catmull_rom_spline_eval_defines.svh
// Assertion helpers used by the checker file crs_checker.sv.
`ifndef CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_DEFINES_SVH

// same-cycle implication
`define CRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/crs_pkg.sv
package crs_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int COORD_W  = 32;
   localparam int COUNT_W  = 7;
   localparam int INDEX_W  = 6;
   localparam int PARAM_W  = 16;
   // param fraction widened to this many bits before scaling to FRAC_BITS
   localparam int PARAM_EXT_W = 24;
   // Horner accumulators: doubled coefficients and partial sums stay below 2^37
   localparam int ACC_W    = 38;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [1:0] COORD_X    = 2'd0;
   localparam logic [1:0] COORD_Y    = 2'd1;
   localparam logic [1:0] COORD_Z    = 2'd2;
   localparam logic [1:0] COORD_LAST = COORD_Z;

   localparam logic [2:0] READ_LAST = 3'd4;

   // multiply-add steps per coordinate
   localparam logic [2:0] STEP_C1H  = 3'd0;
   localparam logic [2:0] STEP_C1D  = 3'd1;
   localparam logic [2:0] STEP_C2H  = 3'd2;
   localparam logic [2:0] STEP_C2D  = 3'd3;
   localparam logic [2:0] STEP_C3H  = 3'd4;
   localparam logic [2:0] STEP_LAST = STEP_C3H;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_COEF,
      ST_MUL,
      ST_ACC,
      ST_STORE,
      ST_DONE
   } crs_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic                      cmd;
      logic [INDEX_W-1:0]        point_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [PARAM_W-1:0]        curve_param;
   } crs_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] tangent_x;
      logic signed [COORD_W-1:0] tangent_y;
      logic signed [COORD_W-1:0] tangent_z;
   } crs_rsp_type;

   function automatic logic signed [COORD_W-1:0] coord_sel(point_type p, logic [1:0] c);
      logic signed [COORD_W-1:0] v;
      case (c)
         COORD_X: v = p.x;
         COORD_Y: v = p.y;
         default: v = p.z;
      endcase
      return v;
   endfunction

   function automatic logic signed [ACC_W-1:0] sext(logic signed [COORD_W-1:0] v);
      return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
   endfunction

   // halve with round half up, then clamp to signed 32 bits
   function automatic logic signed [COORD_W-1:0] half_sat(logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      logic signed [COORD_W-1:0] s;
      r = v + {{(ACC_W-1){1'b0}}, 1'b1};
      r = r >>> 1;
      if ((r[ACC_W-1:COORD_W-1] == '0) || (r[ACC_W-1:COORD_W-1] == '1)) begin
         s = r[COORD_W-1:0];
      end else if (r[ACC_W-1]) begin
         s = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         s = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

// File: rtl/core/catmull_rom_spline_eval.sv
// Closed-loop Catmull-Rom spline evaluator. A write word (cmd 0) stores one
// Q16.16 control point in the point memory; the block is ready again the
// next cycle. An evaluate word (cmd 1) scales curve_param by point_count to
// pick a segment and local t, reads the four wrapped neighbor points and
// returns position and d/dt, saturated Q16.16. After acceptance an evaluate
// keeps req_ready low through setup, four point memory reads, then per
// coordinate a coefficient step, five multiply/round/add passes on the
// shared multiplier and a store, and the hand-off to the output register,
// which waits while a result there is stalled. The output register lets
// the next word be taken while a result waits. Points never written since
// reset read as garbage. csr_wdata sets point_count (0 acts as 1,
// values above MAX_POINTS act as MAX_POINTS); write it only while idle.
module catmull_rom_spline_eval #(
   parameter int MAX_POINTS = crs_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = crs_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  crs_pkg::crs_req_type         req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output crs_pkg::crs_rsp_type         rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [crs_pkg::COUNT_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int ACC_W = crs_pkg::ACC_W;
   localparam int CW    = crs_pkg::COORD_W;
   localparam int NW    = crs_pkg::COUNT_W;

   crs_pkg::crs_state_type state_ff, state_in;

   logic [NW-1:0]                    point_count_ff, point_count_in;
   logic [crs_pkg::PARAM_W-1:0]      param_ff, param_in;
   logic [FRAC_BITS-1:0]             f_ff, f_in;
   logic [NW-1:0]                    rd_idx_ff, rd_idx_in;
   logic [2:0]                       rd_cnt_ff, rd_cnt_in;
   logic [2:0]                       step_ff, step_in;
   logic [1:0]                       crd_ff, crd_in;
   crs_pkg::point_type               pts_ff [4];
   crs_pkg::point_type               pts_in [4];
   logic signed [ACC_W-1:0]          h_ff, h_in, d_ff, d_in;
   logic signed [ACC_W-1:0]          c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic signed [CW-1:0]             pos_ff [3];
   logic signed [CW-1:0]             pos_in [3];
   logic signed [CW-1:0]             tan_ff [3];
   logic signed [CW-1:0]             tan_in [3];
   logic                             rsp_valid_ff, rsp_valid_in;
   crs_pkg::crs_rsp_type             rsp_data_ff, rsp_data_in;

   logic                             req_fire;
   logic                             mem_wr_en;
   logic                             mem_rd_en;
   logic                             mac_load;
   logic                             rsp_load;
   crs_pkg::point_type               wr_point;
   crs_pkg::point_type               rd_point;

   logic [NW-1:0]                    n_eff;
   logic [crs_pkg::PARAM_W+NW-1:0]   prod;
   logic [NW-1:0]                    seg;
   logic [crs_pkg::PARAM_EXT_W-1:0]  low_ext;
   logic [NW:0]                      idx_sum;
   logic [NW-1:0]                    idx0;
   logic [NW-1:0]                    idx_inc;
   logic [NW-1:0]                    idx_next;

   logic signed [ACC_W-1:0]          e0, e1, e2, e3, e12;
   logic signed [ACC_W-1:0]          k0, k1, k2, k3;
   logic signed [ACC_W-1:0]          mac_op, mac_add, mac_res;

   // ---------------- control ----------------
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crs_pkg::ST_IDLE: begin
            if (req_fire && (req_data.cmd == crs_pkg::CMD_EVAL)) begin
               state_in = crs_pkg::ST_SETUP;
            end
         end
         crs_pkg::ST_SETUP: state_in = crs_pkg::ST_READ;
         crs_pkg::ST_READ: begin
            if (rd_cnt_ff == crs_pkg::READ_LAST) begin
               state_in = crs_pkg::ST_COEF;
            end
         end
         crs_pkg::ST_COEF: state_in = crs_pkg::ST_MUL;
         crs_pkg::ST_MUL:  state_in = crs_pkg::ST_ACC;
         crs_pkg::ST_ACC: begin
            state_in = (step_ff == crs_pkg::STEP_LAST) ? crs_pkg::ST_STORE : crs_pkg::ST_MUL;
         end
         crs_pkg::ST_STORE: begin
            state_in = (crd_ff == crs_pkg::COORD_LAST) ? crs_pkg::ST_DONE : crs_pkg::ST_COEF;
         end
         crs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = crs_pkg::ST_IDLE;
            end
         end
         default: state_in = crs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      mem_rd_en = 1'b0;
      mac_load  = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         crs_pkg::ST_IDLE:  req_ready = 1'b1;
         crs_pkg::ST_READ:  mem_rd_en = (rd_cnt_ff != crs_pkg::READ_LAST);
         crs_pkg::ST_MUL:   mac_load  = 1'b1;
         crs_pkg::ST_DONE:  rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // ---------------- point memory ----------------
   assign mem_wr_en = req_fire && (req_data.cmd == crs_pkg::CMD_WRITE) &&
                      ({26'd0, req_data.point_index} < 32'(MAX_POINTS));
   assign wr_point  = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};

   crs_point_mem #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (IDX_W)
   ) u_point_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (IDX_W'(req_data.point_index)),
      .wr_data (wr_point),
      .rd_en   (mem_rd_en),
      .rd_addr (IDX_W'(rd_idx_ff)),
      .rd_data (rd_point)
   );

   // ---------------- segment and index ----------------
   always_comb begin
      if (point_count_ff == '0) begin
         n_eff = {{(NW-1){1'b0}}, 1'b1};
      end else if ({25'd0, point_count_ff} > 32'(MAX_POINTS)) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = point_count_ff;
      end
   end

   assign prod    = param_ff * {{crs_pkg::PARAM_W{1'b0}}, n_eff};
   assign seg     = prod[crs_pkg::PARAM_W +: NW];
   assign low_ext = {prod[crs_pkg::PARAM_W-1:0], {(crs_pkg::PARAM_EXT_W-crs_pkg::PARAM_W){1'b0}}};
   // seg < n, so one subtract wraps seg - 1
   assign idx_sum = {1'b0, seg} + {1'b0, n_eff} - {{NW{1'b0}}, 1'b1};
   assign idx0    = (idx_sum >= {1'b0, n_eff}) ? NW'(idx_sum - {1'b0, n_eff}) : idx_sum[NW-1:0];
   assign idx_inc = rd_idx_ff + {{(NW-1){1'b0}}, 1'b1};
   assign idx_next = (idx_inc == n_eff) ? '0 : idx_inc;

   // ---------------- doubled basis coefficients ----------------
   assign e0  = crs_pkg::sext(crs_pkg::coord_sel(pts_ff[0], crd_ff));
   assign e1  = crs_pkg::sext(crs_pkg::coord_sel(pts_ff[1], crd_ff));
   assign e2  = crs_pkg::sext(crs_pkg::coord_sel(pts_ff[2], crd_ff));
   assign e3  = crs_pkg::sext(crs_pkg::coord_sel(pts_ff[3], crd_ff));
   assign e12 = e1 - e2;
   assign k0  = e3 - e0 + e12 + (e12 <<< 1);
   assign k1  = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
   assign k2  = e2 - e0;
   assign k3  = e1 <<< 1;

   // ---------------- shared multiplier ----------------
   always_comb begin
      case (step_ff)
         crs_pkg::STEP_C1D, crs_pkg::STEP_C2D: mac_op = d_ff;
         default:                              mac_op = h_ff;
      endcase
      case (step_ff)
         crs_pkg::STEP_C1H: mac_add = c1_ff;
         crs_pkg::STEP_C1D: mac_add = c1_ff <<< 1;
         crs_pkg::STEP_C2H,
         crs_pkg::STEP_C2D: mac_add = c2_ff;
         default:           mac_add = c3_ff;
      endcase
   end

   crs_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock  (clock),
      .load   (mac_load),
      .op_a   (mac_op),
      .frac   (f_ff),
      .addend (mac_add),
      .result (mac_res)
   );

   // ---------------- datapath next values ----------------
   always_comb begin
      point_count_in = point_count_ff;
      param_in       = param_ff;
      f_in           = f_ff;
      rd_idx_in      = rd_idx_ff;
      rd_cnt_in      = rd_cnt_ff;
      step_in        = step_ff;
      crd_in         = crd_ff;
      pts_in         = pts_ff;
      h_in           = h_ff;
      d_in           = d_ff;
      c1_in          = c1_ff;
      c2_in          = c2_ff;
      c3_in          = c3_ff;
      pos_in         = pos_ff;
      tan_in         = tan_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (csr_valid && csr_ready) begin
         point_count_in = csr_wdata;
      end
      if (req_fire) begin
         param_in = req_data.curve_param;
      end

      case (state_ff)
         crs_pkg::ST_SETUP: begin
            f_in      = FRAC_BITS'(low_ext >> (crs_pkg::PARAM_EXT_W - FRAC_BITS));
            rd_idx_in = idx0;
            rd_cnt_in = '0;
            crd_in    = crs_pkg::COORD_X;
         end
         crs_pkg::ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            rd_idx_in = idx_next;
            // read data arrives in the cycle after its address
            if (rd_cnt_ff != '0) begin
               pts_in[0] = pts_ff[1];
               pts_in[1] = pts_ff[2];
               pts_in[2] = pts_ff[3];
               pts_in[3] = rd_point;
            end
         end
         crs_pkg::ST_COEF: begin
            h_in    = k0;
            d_in    = k0 + (k0 <<< 1);
            c1_in   = k1;
            c2_in   = k2;
            c3_in   = k3;
            step_in = crs_pkg::STEP_C1H;
         end
         crs_pkg::ST_ACC: begin
            if ((step_ff == crs_pkg::STEP_C1D) || (step_ff == crs_pkg::STEP_C2D)) begin
               d_in = mac_res;
            end else begin
               h_in = mac_res;
            end
            step_in = step_ff + 3'd1;
         end
         crs_pkg::ST_STORE: begin
            pos_in[crd_ff] = crs_pkg::half_sat(h_ff);
            tan_in[crd_ff] = crs_pkg::half_sat(d_ff);
            crd_in         = crd_ff + 2'd1;
         end
         default: begin
         end
      endcase

      if (rsp_load) begin
         rsp_data_in.pos_x     = pos_ff[0];
         rsp_data_in.pos_y     = pos_ff[1];
         rsp_data_in.pos_z     = pos_ff[2];
         rsp_data_in.tangent_x = tan_ff[0];
         rsp_data_in.tangent_y = tan_ff[1];
         rsp_data_in.tangent_z = tan_ff[2];
         rsp_valid_in          = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= crs_pkg::ST_IDLE;
         point_count_ff <= crs_pkg::COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
         rd_cnt_ff      <= '0;
         step_ff        <= '0;
         crd_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_cnt_ff      <= rd_cnt_in;
         step_ff        <= step_in;
         crd_ff         <= crd_in;
      end
   end

   always_ff @(posedge clock) begin
      param_ff    <= param_in;
      f_ff        <= f_in;
      rd_idx_ff   <= rd_idx_in;
      pts_ff      <= pts_in;
      h_ff        <= h_in;
      d_ff        <= d_in;
      c1_ff       <= c1_in;
      c2_ff       <= c2_in;
      c3_ff       <= c3_in;
      pos_ff      <= pos_in;
      tan_ff      <= tan_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/crs_point_mem.sv
module crs_point_mem #(
   parameter int DEPTH  = crs_pkg::MAX_POINTS_DEF,
   parameter int ADDR_W = $clog2(crs_pkg::MAX_POINTS_DEF)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  crs_pkg::point_type wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output crs_pkg::point_type rd_data
);

   crs_pkg::point_type mem_q [DEPTH];
   crs_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/crs_mac.sv
// Shared multiply / round / add unit: product registered, then
// result = round_half_up(op_a * frac / 2^FRAC_BITS) + addend.
module crs_mac #(
   parameter int FRAC_BITS = crs_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             load,
   input  logic signed [crs_pkg::ACC_W-1:0] op_a,
   input  logic [FRAC_BITS-1:0]             frac,
   input  logic signed [crs_pkg::ACC_W-1:0] addend,
   output logic signed [crs_pkg::ACC_W-1:0] result
);

   localparam int PROD_W = crs_pkg::ACC_W + FRAC_BITS + 1;

   logic signed [PROD_W-1:0] a_ext;
   logic signed [PROD_W-1:0] f_ext;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] rnd;
   logic signed [PROD_W-1:0] shifted;

   assign a_ext   = {{(PROD_W-crs_pkg::ACC_W){op_a[crs_pkg::ACC_W-1]}}, op_a};
   assign f_ext   = {{(PROD_W-FRAC_BITS){1'b0}}, frac};
   assign prod_in = a_ext * f_ext;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign rnd     = prod_ff + ({{(PROD_W-1){1'b0}}, 1'b1} <<< (FRAC_BITS-1));
   assign shifted = rnd >>> FRAC_BITS;
   assign result  = shifted[crs_pkg::ACC_W-1:0] + addend;

endmodule

// File: rtl/core/crs_checker.sv
`include "catmull_rom_spline_eval_defines.svh"

module crs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input crs_pkg::crs_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input crs_pkg::crs_rsp_type rsp_data
);

   logic req_fire;

   assign req_fire = req_valid && req_ready;

   // a stalled result word holds
   `CRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word dropped or changed while stalled")

   // evaluate words occupy the block
   `CRS_ASSERT_NEXT(a_eval_busy, clock, reset, req_fire && (req_data.cmd == crs_pkg::CMD_EVAL), !req_ready, "ready stayed high after an evaluate word")

   // write words do not
   `CRS_ASSERT_NEXT(a_write_quick, clock, reset, req_fire && (req_data.cmd == crs_pkg::CMD_WRITE), req_ready, "ready dropped after a write word")

   // a new result only appears at the end of an evaluation
   `CRS_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), !$past(req_ready), "result word appeared while idle")

endmodule

bind catmull_rom_spline_eval crs_checker u_crs_checker (.*);

// File: bench/catmull_rom_spline_check.sv
`timescale 1ns / 1ps
// Watches the three channels, keeps its own copy of the point memory and the
// loop count, predicts one curve word per evaluate and compares responses.
module catmull_rom_spline_check (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  crs_pkg::crs_req_type         req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  crs_pkg::crs_rsp_type         rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [crs_pkg::COUNT_W-1:0]  csr_wdata,
   output int                           curve_errs,
   output int                           curve_pts_due
);
   import crs_pkg::*;

   localparam int LOOP_MAX = MAX_POINTS_DEF;
   localparam int FRAC_W   = FRAC_BITS_DEF;
   localparam int REPORT_MAX = 10;
   localparam longint Q_MAX = 64'sh7FFF_FFFF;
   localparam longint Q_MIN = -64'sh8000_0000;

   point_type          point_mem [LOOP_MAX];
   logic [COUNT_W-1:0] loop_count;
   crs_rsp_type        expected_curve_pts [$];
   string field_name [6] = '{"pos_x", "pos_y", "pos_z",
                             "tangent_x", "tangent_y", "tangent_z"};

   // divide by 2^k, ties go toward plus infinity
   function automatic longint half_up(input longint v, input int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_q16(input longint v);
      if (v > Q_MAX) return Q_MAX[COORD_W-1:0];
      if (v < Q_MIN) return Q_MIN[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   function automatic crs_rsp_type spline_at(input logic [PARAM_W-1:0] param);
      int unsigned n, prod, seg;
      int unsigned slot [4];
      longint frac, c0, c1, c2, c3, h, d;
      longint p [4];
      logic signed [COORD_W-1:0] pos [3];
      logic signed [COORD_W-1:0] slope [3];
      crs_rsp_type r;
      n = loop_count;
      if (n == 0) n = 1;
      if (n > LOOP_MAX) n = LOOP_MAX;
      prod = param * n;
      seg  = prod >> PARAM_W;
      frac = longint'(((prod & 32'hFFFF) << (PARAM_EXT_W - PARAM_W)) >> (PARAM_EXT_W - FRAC_W));
      slot[0] = (seg + n - 1) % n;
      for (int k = 1; k < 4; k++) slot[k] = (slot[k-1] + 1) % n;
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 4; k++) begin
            case (c)
               0: p[k] = $signed(point_mem[slot[k]].x);
               1: p[k] = $signed(point_mem[slot[k]].y);
               default: p[k] = $signed(point_mem[slot[k]].z);
            endcase
         end
         // basis coefficients kept doubled so they stay integers
         c0 = -p[0] + 3 * p[1] - 3 * p[2] + p[3];
         c1 = 2 * p[0] - 5 * p[1] + 4 * p[2] - p[3];
         c2 = p[2] - p[0];
         c3 = 2 * p[1];
         h = half_up(c0 * frac, FRAC_W) + c1;
         h = half_up(h * frac, FRAC_W) + c2;
         h = half_up(h * frac, FRAC_W) + c3;
         d = half_up(3 * c0 * frac, FRAC_W) + 2 * c1;
         d = half_up(d * frac, FRAC_W) + c2;
         pos[c]   = clamp_q16(half_up(h, 1));
         slope[c] = clamp_q16(half_up(d, 1));
      end
      r.pos_x     = pos[0];
      r.pos_y     = pos[1];
      r.pos_z     = pos[2];
      r.tangent_x = slope[0];
      r.tangent_y = slope[1];
      r.tangent_z = slope[2];
      return r;
   endfunction

   task automatic count_error(input string msg);
      curve_errs++;
      if (curve_errs <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      crs_rsp_type want;
      if (reset) begin
         loop_count = COUNT_RESET;
         expected_curve_pts.delete();
         for (int i = 0; i < LOOP_MAX; i++) point_mem[i] = '0;
      end else begin
         if (csr_valid && csr_ready) loop_count = csr_wdata;
         if (req_valid && req_ready) begin
            if (req_data.cmd == CMD_WRITE) begin
               if (req_data.point_index < LOOP_MAX)
                  point_mem[req_data.point_index] =
                     {req_data.coord_x, req_data.coord_y, req_data.coord_z};
            end else begin
               expected_curve_pts.push_back(spline_at(req_data.curve_param));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_curve_pts.size() == 0) begin
               count_error($sformatf("curve word with none due: %h", rsp_data));
            end else begin
               want = expected_curve_pts.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (want[191 - 32*i -: 32] !== rsp_data[191 - 32*i -: 32])
                     count_error($sformatf("%s mismatch: expected %0d, got %0d",
                        field_name[i], $signed(want[191 - 32*i -: 32]),
                        $signed(rsp_data[191 - 32*i -: 32])));
               end
            end
         end
      end
      curve_pts_due = expected_curve_pts.size();
   end

endmodule

// File: bench/tb_catmull_rom_spline_eval.sv
`timescale 1ns / 1ps
module tb_catmull_rom_spline_eval;
   import crs_pkg::*;

   localparam int LOOP_MAX      = MAX_POINTS_DEF;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_WORDS   = 75;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   crs_req_type        req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   crs_rsp_type        rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_wdata;
   int                 curve_errs;
   int                 curve_pts_due;

   int loop_n;
   bit loaded [LOOP_MAX];
   int calm_words;

   catmull_rom_spline_eval dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   catmull_rom_spline_check check_u (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .curve_errs    (curve_errs),
      .curve_pts_due (curve_pts_due)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 5) return $urandom;
      return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
   endfunction

   function automatic logic [PARAM_W-1:0] pick_param();
      int unsigned sel, k;
      sel = $urandom_range(0, 9);
      if (sel < 8) return PARAM_W'($urandom_range(0, 16'hFFFF));
      if (sel == 8) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      // first parameter value that lands in segment k
      k = $urandom_range(0, loop_n - 1);
      return PARAM_W'((k * 65536 + loop_n - 1) / loop_n);
   endfunction

   task automatic push_word(input crs_req_type w);
      int gap;
      if (calm_words > 0) begin
         calm_words--;
         gap = 0;
      end else begin
         gap = gap_len();
         if ($urandom_range(0, 99) == 0) calm_words = 40;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic load_point(input int slot, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
      crs_req_type w;
      w.cmd         = CMD_WRITE;
      w.point_index = INDEX_W'(slot);
      w.coord_x     = x;
      w.coord_y     = y;
      w.coord_z     = z;
      w.curve_param = PARAM_W'($urandom);
      push_word(w);
      loaded[slot] = 1'b1;
   endtask

   task automatic load_random(input int slot);
      load_point(slot, rand_coord(), rand_coord(), rand_coord());
   endtask

   task automatic eval_at(input logic [PARAM_W-1:0] param);
      crs_req_type w;
      // every slot of the loop must hold a point before it can be read
      for (int i = 0; i < loop_n; i++) if (!loaded[i]) load_random(i);
      w.cmd         = CMD_EVAL;
      w.point_index = INDEX_W'($urandom);
      w.coord_x     = $urandom;
      w.coord_y     = $urandom;
      w.coord_z     = $urandom;
      w.curve_param = param;
      push_word(w);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (curve_pts_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_count(input logic [COUNT_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      loop_n = (v == 0) ? 1 : ((v > LOOP_MAX) ? LOOP_MAX : v);
   endtask

   initial begin : rsp_side
      int hold, steady;
      hold = 0;
      steady = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            if (steady > 0) steady--;
            else if ($urandom_range(0, 299) == 0) steady = 400;
            else if ($urandom_range(0, 2) == 0) hold = gap_len();
         end
      end
   end

   // ends the run if no word moves on any channel for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle = 0;
         else
            idle++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int pick;
      int phase_counts [10];
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      calm_words = 0;
      loop_n     = COUNT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // alternating extremes force overshoot and saturation
      load_point(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      load_point(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      load_point(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      load_point(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      eval_at(16'h0000);
      eval_at(16'hFFFF);
      eval_at(16'h4000);
      eval_at(16'h2000);
      eval_at(16'h0001);
      load_point(63, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      load_point(2, 32'h0003_0000, 32'h0000_0000, 32'hFFFE_8000);
      eval_at(16'h6000);
      // single point: every neighbor is slot 0
      set_count(1);
      eval_at(16'h0000);
      eval_at(16'hFFFF);
      eval_at(16'h8123);
      // a count of zero behaves as one
      set_count(0);
      eval_at(16'hFFFF);
      eval_at(16'h1234);

      phase_counts = '{2, 64, 127, 0, $urandom_range(3, 16), $urandom_range(17, 63),
                       1, $urandom_range(65, 126), 3, COUNT_RESET};
      for (int ph = 0; ph < 10; ph++) begin
         set_count(COUNT_W'(phase_counts[ph]));
         for (int w = 0; w < PHASE_WORDS; w++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) eval_at(pick_param());
            else if (pick < 90) load_random($urandom_range(0, loop_n - 1));
            else load_random($urandom_range(0, LOOP_MAX - 1));
         end
      end

      drain();
      if (curve_errs == 0 && curve_pts_due == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
